>>> hdl/assert_macros.svh
// Assertion macros shared by the pooling engine RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hdl/mape_pkg.sv
// Package for the max/average pooling engine: sizes, register indexes,
// sequencer states and the reciprocal table of the mean. No dependencies.
package mape_pkg;

    localparam int MAX_WINDOW    = 4;
    localparam int MAX_MAP_WIDTH = 64;
    localparam int SAMPLE_BITS   = 16;

    localparam int STORE_DEPTH   = MAX_WINDOW * MAX_MAP_WIDTH;
    localparam int ADDR_BITS     = $clog2(STORE_DEPTH);
    localparam int ROW_SEL_BITS  = $clog2(MAX_WINDOW);
    localparam int COL_BITS      = $clog2(MAX_MAP_WIDTH);
    localparam int SUM_BITS      = SAMPLE_BITS + 2 * ROW_SEL_BITS;
    localparam int DIV_STEPS     = 6;
    localparam int RECIP_SHIFT   = 22;
    localparam int RECIP_BITS    = RECIP_SHIFT + 1;
    localparam int PROD_BITS     = SUM_BITS + RECIP_BITS;
    localparam int QUOT_BITS     = SAMPLE_BITS + 1;

    localparam logic [2:0] CFG_POOL_MODE     = 3'd0;
    localparam logic [2:0] CFG_WINDOW_SIZE   = 3'd1;
    localparam logic [2:0] CFG_WINDOW_STRIDE = 3'd2;
    localparam logic [2:0] CFG_MAP_HEIGHT    = 3'd3;
    localparam logic [2:0] CFG_MAP_WIDTH     = 3'd4;
    localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd5;

    localparam logic MODE_MAX     = 1'b0;
    localparam logic MODE_AVERAGE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_EMIT
    } t_state;

    // Scaled reciprocal of the window area, exact for every window sum.
    function automatic logic [RECIP_BITS-1:0] mean_recip(input logic [2:0] side);
        logic [RECIP_BITS-1:0] v;
        case (side)
            3'd2:    v = RECIP_BITS'(1) << (RECIP_SHIFT - 2);
            3'd3:    v = RECIP_BITS'(466034);
            3'd4:    v = RECIP_BITS'(1) << (RECIP_SHIFT - 4);
            default: v = RECIP_BITS'(1) << RECIP_SHIFT;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/mape_if.sv
// Handshake interfaces of the pooling engine: samples, results and register writes.
// Depends on mape_pkg for field widths.
interface mape_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mape_pkg::SAMPLE_BITS-1:0] sample_value;
    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface mape_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mape_pkg::SAMPLE_BITS-1:0] pooled_value;
    logic [7:0]                            out_channel;
    logic [5:0]                            out_row;
    logic [5:0]                            out_col;
    logic                                  last_of_map;
    modport source (output valid, output pooled_value, output out_channel,
                    output out_row, output out_col, output last_of_map, input ready);
    modport sink   (input valid, input pooled_value, input out_channel,
                    input out_row, input out_col, input last_of_map, output ready);
endinterface

interface mape_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [8:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/max_average_pooling_engine.sv
// Max/average pooling engine: row store, window scan sequencer and result register.
// Depends on mape_pkg, the interfaces in mape_if.sv and assert_macros.svh.
//
//  Channel   Direction  Payload                                        Accepted when
//  i_sample  in         sample_value                                   valid & ready
//  o_result  out        pooled_value, out_channel, out_row, out_col,   valid & ready
//                       last_of_map
//  i_cfg     in         index, data                                    valid & ready
//
// A sample whose row or column is still short of the window side starts no scan.
// Any other sample then scans its window, with S*S reads of the single store port
// and the six-step stride divider; one that closes a window then passes through the
// emit state, after the multiply state for a mean.
// Synchronous active-low reset clears counters and sequencer, config gets defaults.
// A full result register stalls the sequencer only when the next result is due.
`include "assert_macros.svh"

module max_average_pooling_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mape_sample_if.sink       i_sample,
    mape_result_if.source     o_result,
    mape_cfg_if.sink          i_cfg
);

    localparam int AB = mape_pkg::ADDR_BITS;
    localparam int RS = mape_pkg::ROW_SEL_BITS;
    localparam int SB = mape_pkg::SUM_BITS;
    localparam int DB = mape_pkg::SAMPLE_BITS;

    logic       r_pool_mode;
    logic [2:0] r_window_size;
    logic [2:0] r_window_stride;
    logic [6:0] r_map_height;
    logic [6:0] r_map_width;
    logic [8:0] r_channel_count;

    logic [2:0] s_eff;
    logic [2:0] t_eff;
    logic [6:0] h_eff;
    logic [6:0] w_eff;
    logic [8:0] ch_eff;

    mape_pkg::t_state r_state, n_state;

    logic [5:0] r_col, r_row;
    logic [7:0] r_chan;

    logic [DB-1:0] r_store [mape_pkg::STORE_DEPTH];
    logic [DB-1:0] r_rd_data;
    logic [AB-1:0] rd_addr;

    logic [5:0] r_row_b, r_col_b;
    logic [7:0] r_cur_chan;
    logic       r_last;

    logic [RS-1:0] r_kh, r_kw;
    logic          r_issue_done;
    logic          r_rd_valid;
    logic          r_first;
    logic signed [DB-1:0] r_best;
    logic signed [SB-1:0] r_sum;

    logic [2:0] r_div_step;
    logic [5:0] r_num_row, r_num_col, r_q_row, r_q_col;
    logic [2:0] r_rem_row, r_rem_col;

    logic [mape_pkg::PROD_BITS-1:0] r_prod;
    logic                           r_neg;

    logic                 r_out_valid;
    logic signed [DB-1:0] r_out_value;
    logic [7:0]           r_out_chan;
    logic [5:0]           r_out_row, r_out_col;
    logic                 r_out_last;

    logic accept, in_ready, rd_issue, scan_done, window_ok, load_out, out_free;

    logic [5:0] cur_col, cur_row;
    logic [7:0] cur_chan;
    logic [5:0] n_col, n_row;
    logic [7:0] n_chan;
    logic       fits;
    logic [5:0] row_b, col_b;
    logic       last_now;

    always_comb begin
        s_eff  = (r_window_size == 3'd0) ? 3'd1 :
                 (r_window_size > 3'(mape_pkg::MAX_WINDOW)) ? 3'(mape_pkg::MAX_WINDOW) :
                 r_window_size;
        t_eff  = (r_window_stride == 3'd0) ? 3'd1 : r_window_stride;
        h_eff  = (r_map_height == 7'd0) ? 7'd1 : (r_map_height > 7'd64) ? 7'd64 : r_map_height;
        w_eff  = (r_map_width == 7'd0) ? 7'd1 :
                 (r_map_width > 7'(mape_pkg::MAX_MAP_WIDTH)) ? 7'(mape_pkg::MAX_MAP_WIDTH) :
                 r_map_width;
        ch_eff = (r_channel_count == 9'd0) ? 9'd1 :
                 (r_channel_count > 9'd256) ? 9'd256 : r_channel_count;
    end

    // Position of the incoming sample, with counters wrapped against the current bounds,
    // the position that follows it, and the window fit, base and last-of-map flag.
    always_comb begin
        logic [6:0] col_p, row_p, col_i, row_i;
        logic [8:0] chan_p, chan_i;
        logic [7:0] row_end, col_end;
        col_p  = {1'b0, r_col};
        row_p  = {1'b0, r_row};
        chan_p = {1'b0, r_chan};
        if (col_p >= w_eff) begin
            col_p = 7'd0;
            row_p = row_p + 7'd1;
        end
        if (row_p >= h_eff) begin
            row_p  = 7'd0;
            chan_p = chan_p + 9'd1;
        end
        if (chan_p >= ch_eff) begin
            chan_p = 9'd0;
        end
        cur_col  = col_p[5:0];
        cur_row  = row_p[5:0];
        cur_chan = chan_p[7:0];

        col_i  = {1'b0, cur_col} + 7'd1;
        row_i  = {1'b0, cur_row};
        chan_i = {1'b0, cur_chan};
        if (col_i >= w_eff) begin
            col_i = 7'd0;
            row_i = row_i + 7'd1;
            if (row_i >= h_eff) begin
                row_i  = 7'd0;
                chan_i = chan_i + 9'd1;
                if (chan_i >= ch_eff) begin
                    chan_i = 9'd0;
                end
            end
        end
        n_col  = col_i[5:0];
        n_row  = row_i[5:0];
        n_chan = chan_i[7:0];

        fits  = ({1'b0, cur_row} + 7'd1 >= {4'd0, s_eff}) &&
                ({1'b0, cur_col} + 7'd1 >= {4'd0, s_eff});
        row_b = 6'({1'b0, cur_row} + 7'd1 - {4'd0, s_eff});
        col_b = 6'({1'b0, cur_col} + 7'd1 - {4'd0, s_eff});
        row_end = {2'd0, cur_row} + 8'd1 + {5'd0, t_eff};
        col_end = {2'd0, cur_col} + 8'd1 + {5'd0, t_eff};
        last_now = ({1'b0, cur_chan} == ch_eff - 9'd1) &&
                   (row_end > {1'b0, h_eff}) && (col_end > {1'b0, w_eff});
    end

    assign accept    = i_sample.valid && in_ready;
    assign out_free  = !r_out_valid || o_result.ready;
    assign window_ok = (r_rem_row == 3'd0) && (r_rem_col == 3'd0);
    assign rd_addr   = {RS'(r_row_b[RS-1:0] + r_kh), 6'(r_col_b + {4'd0, r_kw})};

    always_comb begin
        n_state = r_state;
        case (r_state)
            mape_pkg::ST_IDLE: begin
                if (accept && fits) begin
                    n_state = mape_pkg::ST_SCAN;
                end
            end
            mape_pkg::ST_SCAN: begin
                if (scan_done) begin
                    if (!window_ok) begin
                        n_state = mape_pkg::ST_IDLE;
                    end else if (r_pool_mode == mape_pkg::MODE_AVERAGE) begin
                        n_state = mape_pkg::ST_MUL;
                    end else begin
                        n_state = mape_pkg::ST_EMIT;
                    end
                end
            end
            mape_pkg::ST_MUL: begin
                n_state = mape_pkg::ST_EMIT;
            end
            mape_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = mape_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mape_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        rd_issue  = 1'b0;
        scan_done = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            mape_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            mape_pkg::ST_SCAN: begin
                rd_issue  = !r_issue_done;
                scan_done = r_issue_done && !r_rd_valid &&
                            (r_div_step == 3'(mape_pkg::DIV_STEPS));
            end
            mape_pkg::ST_EMIT: begin
                load_out = out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign i_sample.ready = in_ready;
    assign i_cfg.ready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_mode     <= mape_pkg::MODE_MAX;
            r_window_size   <= 3'd2;
            r_window_stride <= 3'd2;
            r_map_height    <= 7'd8;
            r_map_width     <= 7'd8;
            r_channel_count <= 9'd1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                mape_pkg::CFG_POOL_MODE:     r_pool_mode     <= i_cfg.data[0];
                mape_pkg::CFG_WINDOW_SIZE:   r_window_size   <= i_cfg.data[2:0];
                mape_pkg::CFG_WINDOW_STRIDE: r_window_stride <= i_cfg.data[2:0];
                mape_pkg::CFG_MAP_HEIGHT:    r_map_height    <= i_cfg.data[6:0];
                mape_pkg::CFG_MAP_WIDTH:     r_map_width     <= i_cfg.data[6:0];
                mape_pkg::CFG_CHANNEL_COUNT: r_channel_count <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_store[{cur_row[RS-1:0], cur_col}] <= i_sample.sample_value;
        end
        r_rd_data <= r_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mape_pkg::ST_IDLE;
            r_col      <= 6'd0;
            r_row      <= 6'd0;
            r_chan     <= 8'd0;
            r_rd_valid <= 1'b0;
            r_div_step <= 3'd0;
            r_issue_done <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= rd_issue;
            if (accept) begin
                r_col        <= n_col;
                r_row        <= n_row;
                r_chan       <= n_chan;
                r_div_step   <= 3'd0;
                r_issue_done <= 1'b0;
            end else begin
                if (r_state == mape_pkg::ST_SCAN &&
                    r_div_step != 3'(mape_pkg::DIV_STEPS)) begin
                    r_div_step <= r_div_step + 3'd1;
                end
                if (rd_issue && ({1'b0, r_kw} == s_eff - 3'd1) &&
                    ({1'b0, r_kh} == s_eff - 3'd1)) begin
                    r_issue_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [3:0] part_r, part_c;
        part_r = {r_rem_row, r_num_row[5]};
        part_c = {r_rem_col, r_num_col[5]};
        if (accept) begin
            r_row_b    <= row_b;
            r_col_b    <= col_b;
            r_cur_chan <= cur_chan;
            r_last     <= last_now;
            r_kh       <= '0;
            r_kw       <= '0;
            r_first    <= 1'b1;
            r_sum      <= '0;
            r_num_row  <= row_b;
            r_num_col  <= col_b;
            r_rem_row  <= 3'd0;
            r_rem_col  <= 3'd0;
            r_q_row    <= 6'd0;
            r_q_col    <= 6'd0;
        end else begin
            if (rd_issue) begin
                if ({1'b0, r_kw} == s_eff - 3'd1) begin
                    r_kw <= '0;
                    r_kh <= r_kh + RS'(1);
                end else begin
                    r_kw <= r_kw + RS'(1);
                end
            end
            if (r_rd_valid) begin
                if (r_first || $signed(r_rd_data) > r_best) begin
                    r_best <= $signed(r_rd_data);
                end
                r_first <= 1'b0;
                r_sum   <= r_sum + SB'($signed(r_rd_data));
            end
            if (r_state == mape_pkg::ST_SCAN && r_div_step != 3'(mape_pkg::DIV_STEPS)) begin
                r_num_row <= {r_num_row[4:0], 1'b0};
                r_num_col <= {r_num_col[4:0], 1'b0};
                if (part_r >= {1'b0, t_eff}) begin
                    r_rem_row <= 3'(part_r - {1'b0, t_eff});
                    r_q_row   <= {r_q_row[4:0], 1'b1};
                end else begin
                    r_rem_row <= part_r[2:0];
                    r_q_row   <= {r_q_row[4:0], 1'b0};
                end
                if (part_c >= {1'b0, t_eff}) begin
                    r_rem_col <= 3'(part_c - {1'b0, t_eff});
                    r_q_col   <= {r_q_col[4:0], 1'b1};
                end else begin
                    r_rem_col <= part_c[2:0];
                    r_q_col   <= {r_q_col[4:0], 1'b0};
                end
            end
        end
    end

    // Mean: magnitude of the sum times a scaled reciprocal, sign restored afterwards.
    always_ff @(posedge i_clk) begin
        logic [SB-1:0] mag;
        mag = r_sum[SB-1] ? SB'(-r_sum) : r_sum;
        if (r_state == mape_pkg::ST_MUL) begin
            r_prod <= mape_pkg::PROD_BITS'(mag) *
                      mape_pkg::PROD_BITS'(mape_pkg::mean_recip(s_eff));
            r_neg  <= r_sum[SB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [mape_pkg::QUOT_BITS-1:0] quot;
        quot = r_prod[mape_pkg::RECIP_SHIFT +: mape_pkg::QUOT_BITS];
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (load_out) begin
            if (r_pool_mode == mape_pkg::MODE_AVERAGE) begin
                r_out_value <= r_neg ? DB'(-quot) : DB'(quot);
            end else begin
                r_out_value <= r_best;
            end
            r_out_chan <= r_cur_chan;
            r_out_row  <= r_q_row;
            r_out_col  <= r_q_col;
            r_out_last <= r_last;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.pooled_value = r_out_value;
    assign o_result.out_channel  = r_out_chan;
    assign o_result.out_row      = r_out_row;
    assign o_result.out_col      = r_out_col;
    assign o_result.last_of_map  = r_out_last;

    `ASSERT_IMPLY(a_load_from_emit, $rose(r_out_valid), $past(r_state) == mape_pkg::ST_EMIT, "result register loaded outside the emit state")
    `ASSERT_IMPLY(a_read_after_scan, r_rd_valid, $past(r_state) == mape_pkg::ST_SCAN, "store read returned outside a window scan")
    `ASSERT_IMPLY(a_scan_bounds, r_state == mape_pkg::ST_SCAN && !r_issue_done, ({1'b0, r_kh} < s_eff) && ({1'b0, r_kw} < s_eff), "window read index beyond the window side")
    `ASSERT_CLK(a_div_bound, r_div_step <= 3'(mape_pkg::DIV_STEPS), "stride divider stepped past its last bit")
    `ASSERT_IMPLY(a_div_remainder, r_state == mape_pkg::ST_SCAN, (r_rem_row < t_eff) && (r_rem_col < t_eff), "stride remainder not below the stride")

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the max/average pooling engine: a directed table,
// then randomised whole-map phases, each result checked against a local model or a directed expectation.
// Depends on mape_pkg, the interfaces in mape_if.sv and the engine RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int ITEMS         = 1900;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 300;
    localparam int PRESSURE_AT   = 300;

    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [15:0] value;
        logic [7:0]  channel;
        logic [5:0]  row;
        logic [5:0]  col;
        logic        last;
    } t_pool;

    typedef struct {
        bit          is_reg;
        logic [2:0]  index;
        logic [8:0]  data;
        logic [15:0] sample;
        bit          typed;
        t_pool       want;
    } t_step;

    typedef enum {SHAPE_SMALL, SHAPE_TALL, SHAPE_WIDE, SHAPE_DEEP, SHAPE_EMPTY} t_shape;

    logic clk;
    logic rst_n;

    mape_sample_if smp ();
    mape_result_if res ();
    mape_cfg_if    cfg ();

    max_average_pooling_engine u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_sample (smp),
        .o_result (res),
        .i_cfg    (cfg)
    );

    logic        mode_q;
    logic [2:0]  size_q;
    logic [2:0]  stride_q;
    logic [6:0]  height_q;
    logic [6:0]  width_q;
    logic [8:0]  channels_q;
    logic [15:0] window_rows [0:mape_pkg::STORE_DEPTH-1];
    int          col_pos;
    int          row_pos;
    int          chan_pos;

    t_pool  pending_pools [$];
    t_pool  head;
    t_step  directed [$];
    int     errors;
    int     idle_cycles;
    bit     sender_gaps;
    bit     receiver_gaps;
    bit     hold_req;
    bit     hold_done;

    initial clk = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [8:0] word);
        case (idx)
            mape_pkg::CFG_POOL_MODE:     mode_q     = word[0];
            mape_pkg::CFG_WINDOW_SIZE:   size_q     = word[2:0];
            mape_pkg::CFG_WINDOW_STRIDE: stride_q   = word[2:0];
            mape_pkg::CFG_MAP_HEIGHT:    height_q   = word[6:0];
            mape_pkg::CFG_MAP_WIDTH:     width_q    = word[6:0];
            mape_pkg::CFG_CHANNEL_COUNT: channels_q = word[8:0];
            default: ;
        endcase
    endfunction

    function automatic logic [8:0] reg_mask(input logic [2:0] idx);
        case (idx)
            mape_pkg::CFG_POOL_MODE:     return 9'h001;
            mape_pkg::CFG_WINDOW_SIZE:   return 9'h007;
            mape_pkg::CFG_WINDOW_STRIDE: return 9'h007;
            mape_pkg::CFG_MAP_HEIGHT:    return 9'h07F;
            mape_pkg::CFG_MAP_WIDTH:     return 9'h07F;
            mape_pkg::CFG_CHANNEL_COUNT: return 9'h1FF;
            default:                     return 9'h000;
        endcase
    endfunction

    function automatic bit pool_window(input logic [15:0] v, output t_pool pooled);
        int s, t, h, w, ch, orow, ocol, sum, best, x, kh, kw;
        bit hit;
        s  = clamp(size_q, 1, mape_pkg::MAX_WINDOW);
        t  = clamp(stride_q, 1, 7);
        h  = clamp(height_q, 1, 64);
        w  = clamp(width_q, 1, mape_pkg::MAX_MAP_WIDTH);
        ch = clamp(channels_q, 1, 256);
        pooled = '0;
        hit = 1'b0;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) begin
            row_pos = 0;
            chan_pos++;
        end
        if (chan_pos >= ch) chan_pos = 0;
        window_rows[(row_pos % mape_pkg::MAX_WINDOW) * mape_pkg::MAX_MAP_WIDTH + col_pos] = v;
        if (row_pos + 1 >= s && col_pos + 1 >= s &&
                (row_pos + 1 - s) % t == 0 && (col_pos + 1 - s) % t == 0) begin
            orow = (row_pos + 1 - s) / t;
            ocol = (col_pos + 1 - s) / t;
            sum  = 0;
            best = -32769;
            for (kh = 0; kh < s; kh++) begin
                for (kw = 0; kw < s; kw++) begin
                    x = int'($signed(window_rows[((row_pos + 1 - s + kh) % mape_pkg::MAX_WINDOW)
                                                 * mape_pkg::MAX_MAP_WIDTH
                                                 + col_pos + 1 - s + kw]));
                    sum += x;
                    if (x > best) best = x;
                end
            end
            pooled.value   = (mode_q == mape_pkg::MODE_AVERAGE) ? 16'(sum / (s * s)) :
                                                                   16'(best);
            pooled.channel = 8'(chan_pos);
            pooled.row     = 6'(orow);
            pooled.col     = 6'(ocol);
            pooled.last    = (chan_pos == ch - 1) && (orow == (h - s) / t) &&
                             (ocol == (w - s) / t);
            hit = 1'b1;
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) begin
                row_pos = 0;
                chan_pos++;
                if (chan_pos >= ch) chan_pos = 0;
            end
        end
        return hit;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic t_step reg_step(input logic [2:0] idx, input logic [8:0] value);
        t_step st;
        st = '{default: '0};
        st.is_reg = 1'b1;
        st.index  = idx;
        st.data   = value;
        return st;
    endfunction

    function automatic t_step sample_step(input logic [15:0] v, input bit typed = 1'b0,
                                          input t_pool want = '0);
        t_step st;
        st = '{default: '0};
        st.sample = v;
        st.typed  = typed;
        st.want   = want;
        return st;
    endfunction

    function automatic t_pool only_result(input logic [15:0] value);
        return '{value, 8'd0, 6'd0, 6'd0, 1'b1};
    endfunction

    function automatic int odd_side();
        int v;
        v = $urandom_range(0, 3);
        return (v == 0) ? 0 : v + 4;
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [8:0] value);
        logic [8:0] word;
        word = (9'($urandom) & ~reg_mask(idx)) | (value & reg_mask(idx));
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= word;
        do @(posedge clk); while (!(cfg.valid && cfg.ready));
        apply_reg(idx, word);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [15:0] v, input bit typed, input t_pool want);
        t_pool got;
        int gap;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            smp.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        smp.valid        <= 1'b1;
        smp.sample_value <= v;
        do @(posedge clk); while (!(smp.valid && smp.ready));
        if (pool_window(v, got)) pending_pools.push_back(typed ? want : got);
    endtask

    task automatic settle();
        @(negedge clk);
        smp.valid <= 1'b0;
        while (pending_pools.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
                res.ready <= 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge clk);
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && res.valid && res.ready) begin
            if (pending_pools.size() == 0) begin
                $display("%0t: unexpected result, expected none, got value %0d ch %0d (%0d,%0d)",
                         $time, res.pooled_value, res.out_channel, res.out_row, res.out_col);
                errors++;
            end else begin
                head = pending_pools.pop_front();
                check_field("pooled_value", int'($signed(head.value)), int'(res.pooled_value));
                check_field("out_channel", int'(head.channel), int'(res.out_channel));
                check_field("out_row", int'(head.row), int'(res.out_row));
                check_field("out_col", int'(head.col), int'(res.out_col));
                check_field("last_of_map", int'(head.last), int'(res.last_of_map));
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (smp.valid && smp.ready) || (res.valid && res.ready) ||
                    (cfg.valid && cfg.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int     i, sent, phase, maps, count, n;
        int     mode_v, size_v, stride_v, h_v, w_v, c_v;
        bit     dirty, squeeze;
        t_shape shape;

        rst_n            = 1'b0;
        smp.valid        = 1'b0;
        smp.sample_value = '0;
        cfg.valid        = 1'b0;
        cfg.index        = '0;
        cfg.data         = '0;
        res.ready        = 1'b0;
        errors           = 0;
        hold_req         = 1'b0;
        hold_done        = 1'b0;
        sender_gaps      = 1'b1;
        receiver_gaps    = 1'b1;
        mode_q           = mape_pkg::MODE_MAX;
        size_q           = 3'd2;
        stride_q         = 3'd2;
        height_q         = 7'd8;
        width_q          = 7'd8;
        channels_q       = 9'd1;
        col_pos          = 0;
        row_pos          = 0;
        chan_pos         = 0;
        foreach (window_rows[k]) window_rows[k] = '0;

        directed.push_back(reg_step(mape_pkg::CFG_MAP_HEIGHT, 9'd2));
        directed.push_back(reg_step(mape_pkg::CFG_MAP_WIDTH, 9'd2));
        directed.push_back(sample_step(16'h7FFF));
        directed.push_back(sample_step(16'h8000));
        directed.push_back(sample_step(16'h0000));
        directed.push_back(sample_step(16'h0001, 1'b1, only_result(16'h7FFF)));
        directed.push_back(sample_step(16'h8000));
        directed.push_back(sample_step(16'h8000));
        directed.push_back(sample_step(16'h8000));
        directed.push_back(sample_step(16'h8000, 1'b1, only_result(16'h8000)));
        directed.push_back(reg_step(mape_pkg::CFG_POOL_MODE, 9'(mape_pkg::MODE_AVERAGE)));
        // A mean of -1/4 must truncate towards zero rather than round down.
        directed.push_back(sample_step(16'hFFFF));
        directed.push_back(sample_step(16'h0000));
        directed.push_back(sample_step(16'h0000));
        directed.push_back(sample_step(16'h0000, 1'b1, only_result(16'h0000)));
        directed.push_back(sample_step(16'h7FFF));
        directed.push_back(sample_step(16'h7FFF));
        directed.push_back(sample_step(16'h7FFF));
        directed.push_back(sample_step(16'h7FFE, 1'b1, only_result(16'h7FFE)));
        directed.push_back(reg_step(mape_pkg::CFG_WINDOW_SIZE, 9'd0));
        directed.push_back(reg_step(mape_pkg::CFG_WINDOW_STRIDE, 9'd0));
        directed.push_back(reg_step(mape_pkg::CFG_MAP_HEIGHT, 9'd0));
        directed.push_back(reg_step(mape_pkg::CFG_MAP_WIDTH, 9'd0));
        directed.push_back(reg_step(mape_pkg::CFG_CHANNEL_COUNT, 9'd0));
        directed.push_back(sample_step(16'h8000, 1'b1, only_result(16'h8000)));
        // An oversized window on a 2x2 map never produces a result.
        directed.push_back(reg_step(mape_pkg::CFG_WINDOW_SIZE, 9'd7));
        directed.push_back(reg_step(mape_pkg::CFG_MAP_HEIGHT, 9'd2));
        directed.push_back(reg_step(mape_pkg::CFG_MAP_WIDTH, 9'd2));
        directed.push_back(sample_step(16'h0005));
        directed.push_back(sample_step(16'hFFFB));
        directed.push_back(sample_step(16'h03E8));
        directed.push_back(sample_step(16'hFC18));

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        dirty = 1'b0;
        for (i = 0; i < directed.size(); i++) begin
            if (directed[i].is_reg) begin
                if (dirty) settle();
                dirty = 1'b0;
                write_reg(directed[i].index, directed[i].data);
            end else begin
                send_sample(directed[i].sample, directed[i].typed, directed[i].want);
                dirty = 1'b1;
            end
        end
        settle();

        sent  = 0;
        phase = 0;
        while (sent < ITEMS) begin
            if (phase < 4) shape = t_shape'(phase + 1);
            else begin
                n = $urandom_range(0, 9);
                shape = t_shape'((n < 6) ? 0 : n - 5);
            end
            squeeze  = !hold_req && sent >= PRESSURE_AT;
            mode_v   = $urandom_range(0, 1);
            size_v   = ($urandom_range(0, 6) == 0) ? odd_side() : $urandom_range(1, 4);
            stride_v = ($urandom_range(0, 6) == 0) ? odd_side() : $urandom_range(1, 4);
            case (shape)
                SHAPE_TALL: begin
                    h_v = $urandom_range(64, 127);
                    w_v = $urandom_range(1, 2);
                    c_v = 1;
                end
                SHAPE_WIDE: begin
                    h_v = $urandom_range(1, 2);
                    w_v = $urandom_range(64, 127);
                    c_v = 1;
                end
                SHAPE_DEEP: begin
                    h_v    = 1;
                    w_v    = 1;
                    c_v    = $urandom_range(200, 511);
                    size_v = $urandom_range(0, 1);
                end
                SHAPE_EMPTY: begin
                    h_v = 0;
                    w_v = $urandom_range(0, 3);
                    c_v = $urandom_range(0, 2);
                end
                default: begin
                    h_v = $urandom_range(1, 10);
                    w_v = $urandom_range(1, 10);
                    c_v = $urandom_range(1, 3);
                end
            endcase
            if (squeeze) begin
                size_v = 1;
                h_v    = 8;
                w_v    = 8;
                c_v    = 1;
            end
            count = clamp(h_v, 1, 64) * clamp(w_v, 1, 64) * clamp(c_v, 1, 256);
            maps  = (count < 60) ? $urandom_range(1, 3) : 1;

            if (sent >= ITEMS * 85 / 100) begin
                sender_gaps   = 1'b0;
                receiver_gaps = 1'b0;
            end else begin
                sender_gaps   = $urandom_range(0, 3) != 0;
                receiver_gaps = $urandom_range(0, 3) != 0;
            end

            write_reg(mape_pkg::CFG_POOL_MODE, 9'(mode_v));
            write_reg(mape_pkg::CFG_WINDOW_SIZE, 9'(size_v));
            write_reg(mape_pkg::CFG_WINDOW_STRIDE, 9'(stride_v));
            write_reg(mape_pkg::CFG_MAP_HEIGHT, 9'(h_v));
            write_reg(mape_pkg::CFG_MAP_WIDTH, 9'(w_v));
            write_reg(mape_pkg::CFG_CHANNEL_COUNT, 9'(c_v));
            if ($urandom_range(0, 3) == 0)
                write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_7 : CFG_SPARE_6, 9'd0);

            if (squeeze) hold_req = 1'b1;
            repeat (maps * count) begin
                send_sample(pick_sample(), 1'b0, '0);
                sent++;
            end
            settle();
            phase++;
        end

        if (errors == 0 && pending_pools.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/mape_pkg.sv
hdl/mape_if.sv
hdl/max_average_pooling_engine.sv
dv/testbench.sv
